// ===== rtl/lps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the LED pattern sequencer: state type, LED constants,
// marker and sparkle tables, and the saturating compare adder.
// No dependencies.
package lps_pkg;

  localparam int unsigned CmpW   = 7;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned SelW   = 3;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CountW = 5;
  localparam int unsigned StepW  = 4;
  localparam int unsigned HeldW  = 8;
  localparam int unsigned ChoiceW = 4;
  localparam int unsigned CfgDataW = 8;

  typedef logic [CmpW-1:0]    cmp_t;
  typedef logic [MaskW-1:0]   mask_t;
  typedef logic [SelW-1:0]    sel_t;
  typedef logic [PhaseW-1:0]  phase_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [StepW-1:0]   step_t;
  typedef logic [HeldW-1:0]   held_t;
  typedef logic [ChoiceW-1:0] choice_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_DUTY_STEP  = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_e;

  localparam step_t DutyStepReset  = 4'd2;
  localparam held_t LongPressReset = 8'd128;

  // LED masks
  localparam mask_t NoLeds    = 8'h00;
  localparam mask_t InnerLed  = 8'h02;
  localparam mask_t OuterLeds = 8'hC8;
  localparam mask_t AllLeds   = 8'hCA;

  // Pattern numbers
  localparam sel_t PatSinglePulse  = 3'd0;
  localparam sel_t PatSingleBreath = 3'd1;
  localparam sel_t PatSingleFlash  = 3'd2;
  localparam sel_t PatFullPulse    = 3'd3;
  localparam sel_t PatFullBreath   = 3'd4;
  localparam sel_t PatFullFlash    = 3'd5;
  localparam sel_t PatSparkle      = 3'd6;
  localparam sel_t PatUnused       = 3'd7;

  // Compare thresholds and preset points
  localparam cmp_t CmpFloor    = 7'h06;
  localparam cmp_t CmpPress    = 7'h08;
  localparam cmp_t CmpMarker   = 7'h10;
  localparam cmp_t CmpSparkle  = 7'h50;
  localparam cmp_t CmpTop      = 7'h70;
  localparam cmp_t CmpQrsEnd   = 7'h10;
  localparam cmp_t CmpFullOn   = 7'h16;
  localparam cmp_t CmpFlash    = 7'h20;
  localparam cmp_t CmpFullOff  = 7'h20;
  localparam cmp_t CmpTEnd     = 7'h30;

  // Blink timing
  localparam count_t MarkLit   = 5'd5;
  localparam count_t MarkDone  = 5'd10;
  localparam count_t FlashLit  = 5'd20;
  localparam count_t FlashDone = 5'd25;

  // Sleep sequence counter
  localparam count_t SleepStart = 5'd16;
  localparam count_t SleepLast  = 5'd20;
  localparam count_t SleepWake  = 5'd2;

  typedef struct packed {
    sel_t   pattern_sel;
    phase_t phase;
    cmp_t   compare;
    count_t flash_count;
    mask_t  on_mask;
    mask_t  off_mask;
    logic   held_flag;
    held_t  held_ticks;
    count_t sleep_count;
    logic   sleeping;
  } lps_state_t;

  localparam lps_state_t StateReset = '{
    pattern_sel: PatSinglePulse,
    phase:       3'd0,
    compare:     CmpFloor,
    flash_count: 5'd0,
    on_mask:     NoLeds,
    off_mask:    AllLeds,
    held_flag:   1'b0,
    held_ticks:  8'd0,
    sleep_count: 5'd0,
    sleeping:    1'b0
  };

  function automatic mask_t marker_mask(sel_t sel);
    mask_t m;
    case (sel)
      3'd0:    m = 8'h40;
      3'd1:    m = 8'h80;
      3'd2:    m = 8'h08;
      3'd3:    m = 8'h42;
      3'd4:    m = 8'h82;
      3'd5:    m = 8'h0A;
      3'd6:    m = 8'h02;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Twelve-entry sparkle table, folded so that codes 12..15 wrap to 0..3
  function automatic mask_t sparkle_mask(choice_t c);
    mask_t m;
    case (c)
      4'd0, 4'd12: m = 8'h40;
      4'd3, 4'd15: m = 8'h80;
      4'd6:        m = 8'h08;
      4'd9:        m = 8'h02;
      default:     m = 8'h00;
    endcase
    return m;
  endfunction

  // Add a signed delta to the compare point, saturating to 0..127
  function automatic cmp_t cmp_add(cmp_t c, logic signed [CmpW-1:0] d);
    logic signed [CmpW+1:0] v;
    v = $signed({2'b00, c}) + (CmpW+2)'(d);
    if (v < 0) begin
      return '0;
    end else if (v > $signed((CmpW+2)'(2**CmpW - 1))) begin
      return '1;
    end
    return v[CmpW-1:0];
  endfunction

endpackage

// ===== rtl/lps_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the LED pattern sequencer.
// Depends on lps_pkg for the payload types.
interface lps_in_if import lps_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    button_down;
  choice_t sparkle_choice;

  modport source (output valid, button_down, sparkle_choice, input ready);
  modport sink (input valid, button_down, sparkle_choice, output ready);
endinterface

interface lps_out_if import lps_pkg::*; ();
  logic  valid;
  logic  ready;
  cmp_t  compare_level;
  mask_t leds_on_mask;
  mask_t leds_off_mask;
  logic  pwm_restart;
  logic  asleep;
  sel_t  pattern_index;

  modport source (output valid, compare_level, leds_on_mask, leds_off_mask, pwm_restart,
                  asleep, pattern_index, input ready);
  modport sink (input valid, compare_level, leds_on_mask, leds_off_mask, pwm_restart,
                asleep, pattern_index, output ready);
endinterface

// ===== rtl/led_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// LED pattern sequencer top level: input register, tick update, result register.
// Depends on lps_pkg, lps_if (lps_in_if, lps_out_if) and lps_step.
//
// One input word per 64 Hz tick (button level and sparkle pick) produces exactly
// one output word: PWM compare point, LED on/off masks, PWM restart flag, sleep
// flag and the current pattern number, all showing the state after the tick.
// The block takes one word every clock cycle while the output is not stalled: the
// word sits in the input register while the tick update runs on it, and is then
// written into the result register. The whole tick update is a single pass of
// next-state logic fed by the state registers, so the loop through the state
// registers sets the rate at one word per cycle. A stalled output holds the
// result register and, once the input register is also full, drops input ready.
// Configuration writes (duty_step at index 0, long_press_ticks at index 1) take
// effect on the next word and are meant to be done while no word is in flight.
module led_pattern_sequencer import lps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  lps_in_if.sink           item_in,
  lps_out_if.source        item_out,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  step_t duty_step_q;
  held_t long_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_step_q  <= DutyStepReset;
      long_press_q <= LongPressReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DUTY_STEP:  duty_step_q  <= cfg_data_i[StepW-1:0];
        CFG_LONG_PRESS: long_press_q <= cfg_data_i[HeldW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic    in_valid_q;
  logic    button_q;
  choice_t choice_q;
  logic    advance;
  logic    out_valid_q;

  // Move the held word into the result register when that register is free
  assign advance      = in_valid_q && (!out_valid_q || item_out.ready);
  assign item_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_in.ready) begin
      in_valid_q <= item_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_in.valid && item_in.ready) begin
      button_q <= item_in.button_down;
      choice_q <= item_in.sparkle_choice;
    end
  end

  // Tick state and the next-state logic
  lps_state_t st_q, st_d;
  logic       restart_d;

  lps_step u_step (
    .st_i             (st_q),
    .duty_step_i      (duty_step_q),
    .long_press_i     (long_press_q),
    .button_down_i    (button_q),
    .sparkle_choice_i (choice_q),
    .st_o             (st_d),
    .restart_o        (restart_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register
  logic restart_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (item_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      restart_q <= restart_d;
    end
  end

  // The output word shows the state right after its tick
  assign item_out.valid         = out_valid_q;
  assign item_out.compare_level = st_q.compare;
  assign item_out.leds_on_mask  = st_q.on_mask;
  assign item_out.leds_off_mask = st_q.off_mask;
  assign item_out.pwm_restart   = restart_q;
  assign item_out.asleep        = st_q.sleeping;
  assign item_out.pattern_index = st_q.pattern_sel;

  // Pattern number stays within the seven patterns
  a_pattern_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pattern_sel != PatUnused)
    else $error("pattern number out of range");

  // While asleep all LEDs stay dark and no PWM restart is issued
  a_sleep_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && st_q.sleeping) |-> (st_q.on_mask == NoLeds && !restart_q))
    else $error("LEDs lit or PWM restarted while asleep");

  // Sleep counter never runs past the end of the sleep sequence
  a_sleep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.sleep_count <= (SleepLast + 5'd1))
    else $error("sleep counter overran");

  // A word moved out of the input register always lands in the result register
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("word lost between input and result register");

endmodule

// ===== rtl/lps_step.sv =====
`timescale 1ns / 1ps
// One-tick next-state logic of the LED pattern sequencer.
// Depends on lps_pkg.
module lps_step import lps_pkg::*; (
  input  lps_state_t st_i,
  input  step_t      duty_step_i,
  input  held_t      long_press_i,
  input  logic       button_down_i,
  input  choice_t    sparkle_choice_i,
  output lps_state_t st_o,
  output logic       restart_o
);

  lps_state_t n;
  logic       restart;
  logic       full;
  logic signed [CmpW-1:0] s1, s2, h1;
  count_t     old_fc;
  count_t     blink_lit, blink_done;
  mask_t      blink_on;
  cmp_t       blink_cmp;
  logic       do_blink;

  assign s1 = $signed({3'b000, duty_step_i});
  assign s2 = $signed({2'b00, duty_step_i, 1'b0});
  assign h1 = $signed({4'b0000, duty_step_i[StepW-1:1]});

  always_comb begin
    n          = st_i;
    restart    = 1'b0;
    full       = (st_i.pattern_sel == PatFullPulse);
    old_fc     = st_i.flash_count;
    do_blink   = 1'b0;
    blink_cmp  = CmpFlash;
    blink_lit  = FlashLit;
    blink_done = FlashDone;
    blink_on   = InnerLed;

    if (n.sleeping && button_down_i) begin
      n.sleeping = 1'b0;
    end

    if (!n.sleeping) begin
      if (n.sleep_count > 5'd15) begin
        do_blink   = 1'b1;
        blink_cmp  = CmpMarker;
        blink_lit  = MarkLit;
        blink_done = MarkDone;
        blink_on   = marker_mask(n.pattern_sel);
      end else if (n.held_flag) begin
        n.compare  = CmpMarker;
        n.off_mask = AllLeds;
        n.on_mask  = marker_mask(n.pattern_sel);
      end else begin
        case (n.pattern_sel)
          PatSinglePulse, PatFullPulse: begin
            case (n.phase)
              3'd0: begin
                n.compare = cmp_add(n.compare, s1);
                if (n.compare >= CmpSparkle) begin
                  n.phase = 3'd1; n.on_mask = InnerLed; n.compare = CmpFloor;
                end
              end
              3'd1: begin
                restart = 1'b1;
                n.compare = cmp_add(n.compare, s2);
                if (n.compare >= CmpTop) begin
                  n.phase = 3'd2; n.on_mask = InnerLed;
                end
              end
              3'd2: begin
                n.compare = cmp_add(n.compare, -s2);
                if (n.compare <= CmpFloor) begin
                  n.phase = 3'd3; n.on_mask = NoLeds;
                end
              end
              3'd3: begin
                n.compare = cmp_add(n.compare, s1);
                if (n.compare >= CmpQrsEnd) begin
                  n.phase = 3'd4; n.on_mask = InnerLed; n.compare = CmpFloor;
                end
              end
              3'd4: begin
                n.compare = cmp_add(n.compare, s1);
                if (full && n.compare >= CmpFullOn) begin
                  n.on_mask = AllLeds; n.off_mask = OuterLeds;
                end
                if (n.compare >= CmpTEnd) begin
                  n.phase = 3'd5; n.on_mask = full ? AllLeds : InnerLed;
                end
              end
              3'd5: begin
                n.compare = cmp_add(n.compare, -s1);
                if (full && n.compare <= CmpFullOff) n.off_mask = AllLeds;
                if (n.compare <= CmpFloor) begin
                  n.phase = 3'd0; n.on_mask = NoLeds;
                end
              end
              default: n.phase = 3'd0;
            endcase
          end
          PatSingleBreath, PatFullBreath: begin
            n.on_mask  = (n.pattern_sel == PatFullBreath) ? OuterLeds : InnerLed;
            n.off_mask = AllLeds;
            case (n.phase)
              3'd1: begin
                restart = 1'b1;
                n.compare = cmp_add(n.compare, h1);
                if (n.compare >= CmpTop) n.phase = 3'd2;
              end
              3'd2: begin
                n.compare = cmp_add(n.compare, -h1);
                if (n.compare <= CmpFloor) n.phase = 3'd1;
              end
              default: n.phase = 3'd1;
            endcase
          end
          PatSingleFlash, PatFullFlash: begin
            do_blink = 1'b1;
            blink_on = (n.pattern_sel == PatFullFlash) ? OuterLeds : InnerLed;
          end
          PatSparkle: begin
            n.off_mask = AllLeds;
            case (n.phase)
              3'd0: begin
                n.on_mask = sparkle_mask(sparkle_choice_i);
                n.phase   = 3'd1;
                restart   = 1'b1;
              end
              3'd1: begin
                n.compare = cmp_add(n.compare, s1);
                if (n.compare >= CmpSparkle) n.phase = 3'd2;
              end
              3'd2: begin
                n.compare = cmp_add(n.compare, -s1);
                if (n.compare <= CmpFloor) n.phase = 3'd0;
              end
              default: n.phase = 3'd0;
            endcase
          end
          default: ;
        endcase
      end

      // Shared blink counter for the flash patterns and the sleep marker
      if (do_blink) begin
        n.compare     = blink_cmp;
        n.flash_count = old_fc + 5'd1;
        if (old_fc > blink_lit) begin
          n.off_mask = AllLeds; n.on_mask = blink_on;
        end
        if (n.flash_count > blink_done) begin
          n.off_mask = AllLeds; n.on_mask = NoLeds; n.flash_count = '0;
        end
      end

      // Button handling
      if (button_down_i) begin
        if (!n.held_flag) begin
          n.held_ticks = '0;
          case (n.pattern_sel)
            PatSparkle: n.pattern_sel = PatSinglePulse;
            PatUnused:  n.pattern_sel = PatSingleBreath;
            default:    n.pattern_sel = n.pattern_sel + 3'd1;
          endcase
          n.compare = CmpPress;
        end
        n.held_flag = 1'b1;
        if (n.held_ticks != '1) n.held_ticks = n.held_ticks + 8'd1;
        if (n.held_ticks > long_press_i) n.sleep_count = SleepStart;
      end else if (n.sleep_count > 5'd15) begin
        n.sleep_count = n.sleep_count + 5'd1;
        if (n.sleep_count > SleepLast) begin
          case (n.pattern_sel)
            PatSinglePulse, PatUnused: n.pattern_sel = PatSparkle;
            default:                   n.pattern_sel = n.pattern_sel - 3'd1;
          endcase
          n.sleeping    = 1'b1;
          n.sleep_count = SleepWake;
          n.held_ticks  = '0;
          n.on_mask     = NoLeds;
          n.off_mask    = AllLeds;
        end
      end else if (n.sleep_count inside {[5'd2:5'd8]}) begin
        n.sleep_count = (n.sleep_count == 5'd8) ? 5'd0 : n.sleep_count + 5'd1;
      end else begin
        if (n.held_flag) begin
          n.on_mask = NoLeds; n.off_mask = AllLeds;
        end
        n.held_flag = 1'b0;
      end
    end

    st_o      = n;
    restart_o = restart;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for led_pattern_sequencer: directed and random tick words,
// a tick-by-tick predictor and an in-order result checker.
// Depends on lps_pkg, lps_if (lps_in_if, lps_out_if) and the block's RTL.
module tb;
  import lps_pkg::*;

  // Ramp thresholds and preset compare points of the light patterns
  localparam cmp_t LowPeak      = 7'h50;
  localparam cmp_t HighPeak     = 7'h70;
  localparam cmp_t RampFloor    = 7'h06;
  localparam cmp_t PressLevel   = 7'h08;
  localparam cmp_t MarkerLevel  = 7'h10;
  localparam cmp_t QrsLimit     = 7'h10;
  localparam cmp_t FullOnLevel  = 7'h16;
  localparam cmp_t FlashLevel   = 7'h20;
  localparam cmp_t FullOffLevel = 7'h20;
  localparam cmp_t TRampTop     = 7'h30;

  localparam count_t MarkerLit  = 5'd5;
  localparam count_t MarkerDone = 5'd10;
  localparam count_t FlashLit   = 5'd20;
  localparam count_t FlashDone  = 5'd25;

  localparam count_t SeqArmed  = 5'd16;
  localparam count_t SeqLast   = 5'd20;
  localparam count_t SeqWoken  = 5'd2;
  localparam count_t SeqSettle = 5'd8;

  localparam int unsigned PatternCount = 7;

  localparam mask_t MarkerMasks [8] = '{8'h40, 8'h80, 8'h08, 8'h42, 8'h82, 8'h0A, 8'h02, 8'h00};
  localparam mask_t SparkleMasks [12] = '{8'h40, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00,
                                          8'h08, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00};

  typedef struct packed {
    logic    button;
    choice_t pick;
  } tick_word_t;

  typedef struct packed {
    cmp_t  level;
    mask_t on_leds;
    mask_t off_leds;
    logic  restart;
    logic  asleep;
    sel_t  pattern;
  } led_frame_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lps_in_if  tick_if ();
  lps_out_if frame_if ();

  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  led_pattern_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in    (tick_if),
    .item_out   (frame_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Predicted sequencer state and its configuration copy
  sel_t   cur_pattern;
  phase_t cur_phase;
  cmp_t   cur_compare;
  count_t blink_count;
  mask_t  on_leds;
  mask_t  off_leds;
  logic   btn_held;
  held_t  hold_ticks;
  count_t sleep_seq;
  logic   dozing;
  logic   restart_now;
  step_t  ramp_step;
  held_t  long_hold;

  tick_word_t pending_ticks [$];
  led_frame_t expected_frames [$];
  tick_word_t next_word;

  int   pushed_ticks;
  int   accepted_ticks;
  int   checked_frames;
  int   mismatch_count;
  int   sleep_entries;
  int   pattern_steps;
  int   idle_odds;
  int   src_gap;
  int   sink_gap;
  logic word_taken;

  // Add a signed delta to the compare point, clamped to the 7-bit range
  function automatic void bump_compare(int delta);
    int v;
    v = int'(cur_compare) + delta;
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    cur_compare = cmp_t'(v);
  endfunction

  function automatic void run_pulse(logic full);
    int s;
    s = int'(ramp_step);
    case (cur_phase)
      3'd0: begin
        bump_compare(s);
        if (cur_compare >= LowPeak) begin
          cur_phase = 3'd1; on_leds = InnerLed; cur_compare = RampFloor;
        end
      end
      3'd1: begin
        restart_now = 1'b1;
        bump_compare(2 * s);
        if (cur_compare >= HighPeak) begin
          cur_phase = 3'd2; on_leds = InnerLed;
        end
      end
      3'd2: begin
        bump_compare(-2 * s);
        if (cur_compare <= RampFloor) begin
          cur_phase = 3'd3; on_leds = NoLeds;
        end
      end
      3'd3: begin
        bump_compare(s);
        if (cur_compare >= QrsLimit) begin
          cur_phase = 3'd4; on_leds = InnerLed; cur_compare = RampFloor;
        end
      end
      3'd4: begin
        bump_compare(s);
        if (full && cur_compare >= FullOnLevel) begin
          on_leds = AllLeds; off_leds = OuterLeds;
        end
        if (cur_compare >= TRampTop) begin
          cur_phase = 3'd5; on_leds = full ? AllLeds : InnerLed;
        end
      end
      3'd5: begin
        bump_compare(-s);
        if (full && cur_compare <= FullOffLevel) off_leds = AllLeds;
        if (cur_compare <= RampFloor) begin
          cur_phase = 3'd0; on_leds = NoLeds;
        end
      end
      default: cur_phase = 3'd0;
    endcase
  endfunction

  function automatic void run_breath(mask_t leds);
    int h;
    h = int'(ramp_step >> 1);
    on_leds = leds;
    off_leds = AllLeds;
    if (cur_phase == 3'd1) begin
      restart_now = 1'b1;
      bump_compare(h);
      if (cur_compare >= HighPeak) cur_phase = 3'd2;
    end else if (cur_phase == 3'd2) begin
      bump_compare(-h);
      if (cur_compare <= RampFloor) cur_phase = 3'd1;
    end else begin
      cur_phase = 3'd1;
    end
  endfunction

  function automatic void run_blink(cmp_t level, count_t lit, mask_t leds, count_t done);
    count_t prior;
    prior = blink_count;
    cur_compare = level;
    blink_count = blink_count + 5'd1;
    if (prior > lit) begin
      off_leds = AllLeds; on_leds = leds;
    end
    if (blink_count > done) begin
      off_leds = AllLeds; on_leds = NoLeds; blink_count = '0;
    end
  endfunction

  // One 64 Hz tick of the sequencer; returns the frame shown after it
  function automatic led_frame_t tick_sequencer(logic btn, choice_t pick);
    led_frame_t f;
    restart_now = 1'b0;
    if (dozing && btn) dozing = 1'b0;
    if (!dozing) begin
      if (sleep_seq >= SeqArmed) begin
        run_blink(MarkerLevel, MarkerLit, MarkerMasks[cur_pattern], MarkerDone);
      end else if (btn_held) begin
        cur_compare = MarkerLevel; off_leds = AllLeds; on_leds = MarkerMasks[cur_pattern];
      end else begin
        case (cur_pattern)
          PatSinglePulse:  run_pulse(1'b0);
          PatSingleBreath: run_breath(InnerLed);
          PatSingleFlash:  run_blink(FlashLevel, FlashLit, InnerLed, FlashDone);
          PatFullPulse:    run_pulse(1'b1);
          PatFullBreath:   run_breath(OuterLeds);
          PatFullFlash:    run_blink(FlashLevel, FlashLit, OuterLeds, FlashDone);
          PatSparkle: begin
            off_leds = AllLeds;
            if (cur_phase == 3'd0) begin
              on_leds = SparkleMasks[int'(pick) % 12];
              cur_phase = 3'd1;
              restart_now = 1'b1;
            end else if (cur_phase == 3'd1) begin
              bump_compare(int'(ramp_step));
              if (cur_compare >= LowPeak) cur_phase = 3'd2;
            end else if (cur_phase == 3'd2) begin
              bump_compare(-int'(ramp_step));
              if (cur_compare <= RampFloor) cur_phase = 3'd0;
            end else begin
              cur_phase = 3'd0;
            end
          end
          default: ;
        endcase
      end

      if (btn) begin
        // A fresh press advances the pattern; holding only counts
        if (!btn_held) begin
          hold_ticks = '0;
          cur_pattern = sel_t'((int'(cur_pattern) + 1) % PatternCount);
          cur_compare = PressLevel;
          pattern_steps++;
        end
        btn_held = 1'b1;
        if (hold_ticks != 8'hFF) hold_ticks = hold_ticks + 8'd1;
        if (hold_ticks > long_hold) sleep_seq = SeqArmed;
      end else if (sleep_seq >= SeqArmed) begin
        sleep_seq = sleep_seq + 5'd1;
        if (sleep_seq > SeqLast) begin
          cur_pattern = sel_t'((int'(cur_pattern) + PatternCount - 1) % PatternCount);
          dozing = 1'b1; sleep_seq = SeqWoken; hold_ticks = '0;
          on_leds = NoLeds; off_leds = AllLeds;
          sleep_entries++;
        end
      end else if (sleep_seq > 5'd1 && sleep_seq <= SeqSettle) begin
        sleep_seq = sleep_seq + 5'd1;
        if (sleep_seq > SeqSettle) sleep_seq = '0;
      end else begin
        if (btn_held) begin
          on_leds = NoLeds; off_leds = AllLeds;
        end
        btn_held = 1'b0;
      end
    end
    f.level    = cur_compare;
    f.on_leds  = on_leds;
    f.off_leds = off_leds;
    f.restart  = restart_now;
    f.asleep   = dozing;
    f.pattern  = cur_pattern;
    return f;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Tick driver: hold the word until taken, then advance or idle for a burst
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
    end else if (!tick_if.valid || word_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        tick_if.valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        src_gap = $urandom_range(1, 14) - 1;
        tick_if.valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        next_word = pending_ticks.pop_front();
        tick_if.valid          <= 1'b1;
        tick_if.button_down    <= next_word.button;
        tick_if.sparkle_choice <= next_word.pick;
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // Frame sink: stall in random bursts
  always @(negedge clk_i) begin
    if (sink_gap > 0) begin
      sink_gap--;
      frame_if.ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      sink_gap = $urandom_range(1, 14) - 1;
      frame_if.ready <= 1'b0;
    end else begin
      frame_if.ready <= 1'b1;
    end
  end

  // Predict on every accepted tick word
  always @(posedge clk_i) begin
    word_taken <= rst_ni && tick_if.valid && tick_if.ready;
    if (rst_ni && tick_if.valid && tick_if.ready) begin
      expected_frames.push_back(tick_sequencer(tick_if.button_down, tick_if.sparkle_choice));
      accepted_ticks++;
    end
  end

  // Check each accepted frame against the oldest prediction
  always @(posedge clk_i) begin
    led_frame_t want;
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      if (expected_frames.size() == 0) begin
        $error("frame with no tick outstanding: pattern %0d", frame_if.pattern_index);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        check_field("compare_level", 8'(want.level), 8'(frame_if.compare_level));
        check_field("leds_on_mask", want.on_leds, frame_if.leds_on_mask);
        check_field("leds_off_mask", want.off_leds, frame_if.leds_off_mask);
        check_field("pwm_restart", 8'(want.restart), 8'(frame_if.pwm_restart));
        check_field("asleep", 8'(want.asleep), 8'(frame_if.asleep));
        check_field("pattern_index", 8'(want.pattern), 8'(frame_if.pattern_index));
        checked_frames++;
      end
    end
  end

  task automatic push_tick(logic btn, choice_t pick);
    tick_word_t w;
    w.button = btn;
    w.pick   = pick;
    pending_ticks.push_back(w);
    pushed_ticks++;
  endtask

  task automatic push_run(logic btn, int len);
    repeat (len) push_tick(btn, choice_t'($urandom_range(0, 15)));
  endtask

  // Hold off until every tick is taken and every frame has been checked
  task automatic wait_drained();
    while (accepted_ticks != pushed_ticks || expected_frames.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DUTY_STEP:  ramp_step = val[StepW-1:0];
      CFG_LONG_PRESS: long_hold = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int step, int hold);
    wait_drained();
    write_reg(CFG_DUTY_STEP, CfgDataW'(step));
    write_reg(CFG_LONG_PRESS, CfgDataW'(hold));
  endtask

  // Mostly button-up runs that let the ramps play out, each closed by a press;
  // now and then bounce noise or a long press that walks into sleep and wakes
  task automatic random_session(int target);
    int  start;
    int  kind;
    bit  did_long;
    start = pushed_ticks;
    did_long = 1'b0;
    while (pushed_ticks - start < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        push_run(1'b0, $urandom_range(1, 40));
      end else if (kind < 15) begin
        push_run(1'b0, $urandom_range(40, 160));
      end else if (kind < 17) begin
        repeat ($urandom_range(2, 6)) begin
          push_tick(1'($urandom_range(0, 1)), choice_t'($urandom_range(0, 15)));
        end
      end else begin
        push_run(1'b0, $urandom_range(1, 6));
      end

      kind = $urandom_range(0, 19);
      if (kind < 3 && (long_hold <= 40 || !did_long)) begin
        did_long = 1'b1;
        push_run(1'b1, int'(long_hold) + $urandom_range(1, 4));
        push_run(1'b0, $urandom_range(3, 12));
        push_run(1'b1, $urandom_range(1, 3));
      end else if (kind < 6) begin
        push_run(1'b1, $urandom_range(5, 20));
      end else begin
        push_run(1'b1, $urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.button_down = 1'b0;
    tick_if.sparkle_choice = '0;
    frame_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_DUTY_STEP;
    cfg_data = '0;
    word_taken = 1'b0;
    src_gap = 0;
    sink_gap = 0;
    idle_odds = 6;
    pushed_ticks = 0;
    accepted_ticks = 0;
    checked_frames = 0;
    mismatch_count = 0;
    sleep_entries = 0;
    pattern_steps = 0;

    // Predictor starts from the reset state
    ramp_step = DutyStepReset;
    long_hold = LongPressReset;
    cur_pattern = PatSinglePulse;
    cur_phase = '0;
    cur_compare = RampFloor;
    blink_count = '0;
    on_leds = NoLeds;
    off_leds = AllLeds;
    btn_held = 1'b0;
    hold_ticks = '0;
    sleep_seq = '0;
    dozing = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: sparkle pick extremes, then a short press through every pattern
    push_tick(1'b0, 4'd0);
    push_tick(1'b0, 4'd15);
    for (int i = 0; i < PatternCount; i++) begin
      push_tick(1'b1, choice_t'(12 + i % 4));
      push_tick(1'b0, choice_t'((i * 5) % 16));
    end

    // Directed: step of 8, long press of 1; blink, sleep, stay asleep, wake
    configure(8, 1);
    push_run(1'b1, 3);
    push_run(1'b0, 6);
    push_tick(1'b0, 4'd15);
    push_tick(1'b1, 4'd11);
    push_tick(1'b0, 4'd12);

    // Random phases over the step and long-press ranges
    configure(2, 254);
    random_session(260);

    idle_odds = 16;
    configure(8, 20);
    random_session(240);

    idle_odds = 4;
    configure(3, 1);
    random_session(200);

    idle_odds = 8;
    configure($urandom_range(2, 8), $urandom_range(1, 254));
    random_session(240);

    // Last stretch runs at full rate on both sides
    idle_odds = 0;
    configure($urandom_range(2, 8), $urandom_range(2, 60));
    random_session(240);

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d ticks and %0d checked frames across seven register settings.",
             pushed_ticks, checked_frames);
    $display("Saw %0d pattern advances and %0d sleep entries.", pattern_steps, sleep_entries);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("PASS led_pattern_sequencer");
    end else begin
      $display("FAIL led_pattern_sequencer");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL led_pattern_sequencer");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/lps_step.sv
rtl/led_pattern_sequencer.sv
tb/sv/tb.sv
